FILE: hw/rtl/timestamp_linear_resampler_macros.svh
// -----------------------------------------------------------------------------
// Resampler assertion macros
// Assertion helpers for the resampler top module.
// -----------------------------------------------------------------------------
`ifndef TIMESTAMP_LINEAR_RESAMPLER_MACROS_SVH
`define TIMESTAMP_LINEAR_RESAMPLER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequence must hold in the cycle after its antecedent.
`define TLR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/tlr_pkg.sv
// -----------------------------------------------------------------------------
// Timestamp resampler package
// Shared widths, codes, defaults and the per-channel state record.
// -----------------------------------------------------------------------------
package tlr_pkg;

  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned GRID_W    = 12;
  localparam int unsigned NG_W      = 13;
  localparam int unsigned PER_W     = 16;
  localparam int unsigned MAXS_W    = 13;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Shared multiplier and divider operand widths.
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = 50;
  localparam int unsigned DVD_W   = 49;
  localparam int unsigned DVS_W   = 32;

  localparam int unsigned DEF_NUM_CHANNELS = 16;
  localparam int unsigned DEF_GRID_CAP     = 4096;
  localparam int unsigned DEF_MAX_RUN      = 64;

  localparam logic [PER_W-1:0]   RST_PERIOD  = 16'd1000;
  localparam logic [MAXS_W-1:0]  RST_MAXS    = 13'd4096;
  localparam logic [STAMP_W-1:0] RST_MAXDUR  = 32'hFFFF_FFFF;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_NONINC  = 3'd1,
    ST_OVERRUN = 3'd2,
    ST_CUT     = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_MAXS   = 2'd1,
    CFG_MAXDUR = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [STAMP_W-1:0]      stamp;
    logic signed [VAL_W-1:0] value;
    logic [NG_W-1:0]         next_grid;
    logic [STAMP_W-1:0]      next_time;
  } chan_state_t;

endpackage

FILE: hw/rtl/tlr_if.sv
// -----------------------------------------------------------------------------
// Resampler channel interfaces
// Valid/ready channels for input requests and resampled result words.
// -----------------------------------------------------------------------------
interface tlr_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [tlr_pkg::CHAN_W-1:0]        chan;
  logic [tlr_pkg::STAMP_W-1:0]       stamp;
  logic signed [tlr_pkg::VAL_W-1:0]  sample_value;

  modport source (output valid, req_type, chan, stamp, sample_value, input ready);
  modport sink   (input valid, req_type, chan, stamp, sample_value, output ready);
endinterface

interface tlr_out_if;
  logic                              valid;
  logic                              ready;
  logic [tlr_pkg::CHAN_W-1:0]        out_chan;
  logic [tlr_pkg::GRID_W-1:0]        grid_index;
  logic signed [tlr_pkg::VAL_W-1:0]  out_value;
  logic                              last_of_run;
  logic [tlr_pkg::ST_W-1:0]          status;

  modport source (output valid, out_chan, grid_index, out_value, last_of_run, status,
                  input ready);
  modport sink   (input valid, out_chan, grid_index, out_value, last_of_run, status,
                  output ready);
endinterface

FILE: hw/rtl/tlr_div.sv
// -----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module tlr_div #(
  parameter int unsigned DVD_W = tlr_pkg::DVD_W,
  parameter int unsigned DVS_W = tlr_pkg::DVS_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/tlr_chan_store.sv
// -----------------------------------------------------------------------------
// Per-channel state store
// One entry per channel with a registered read; a valid bit per entry stands
// for the cleared state, so a start request clears all channels at once.
// -----------------------------------------------------------------------------
module tlr_chan_store #(
  parameter int unsigned NUM_CHANNELS = tlr_pkg::DEF_NUM_CHANNELS,
  parameter int unsigned IDX_W        = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_idx_i,
  output tlr_pkg::chan_state_t  rd_data_o,
  output logic                  rd_valid_o,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_idx_i,
  input  tlr_pkg::chan_state_t  wr_data_i
);

  tlr_pkg::chan_state_t        mem_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]     valid_q, valid_d;
  tlr_pkg::chan_state_t        rd_q;
  logic                        rd_valid_q, rd_valid_d;

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = '0;
    end else if (wr_en_i) begin
      valid_d[wr_idx_i] = 1'b1;
    end
    rd_valid_d = rd_en_i ? valid_q[rd_idx_i] : rd_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  // An entry that was never written since the last clear reads as zero.
  assign rd_data_o  = rd_valid_q ? rd_q : '0;
  assign rd_valid_o = rd_valid_q;

endmodule

FILE: hw/rtl/timestamp_linear_resampler.sv
// -----------------------------------------------------------------------------
// Timestamp linear resampler
// Resamples channel-tagged, irregularly stamped ADC words onto a fixed grid.
//
//   Channel | Dir | Payload
//   in_i    | in  | req_type, chan, stamp, sample_value
//   out_o   | out | out_chan, grid_index, out_value, last_of_run, status
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// A polled word keeps the block busy from its accept through load, check and a
// loop that emits one grid point at a time; a first-value point needs no divide,
// and each interpolated point waits on the 49-step shared divider. A run cut adds
// a divide and a multiply that skip ahead, and a flag-only word adds a flag state.
// A start request or a word for an absent channel leaves the block idle.
// Reset is asynchronous and clears all channels; in_i.ready is low while a
// word is in work, and a stalled out_o holds the sequencer before each result.
// -----------------------------------------------------------------------------
`include "timestamp_linear_resampler_macros.svh"

module timestamp_linear_resampler #(
  parameter int unsigned NUM_CHANNELS = tlr_pkg::DEF_NUM_CHANNELS,
  parameter int unsigned GRID_CAP     = tlr_pkg::DEF_GRID_CAP,
  parameter int unsigned MAX_RUN      = tlr_pkg::DEF_MAX_RUN
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tlr_in_if.sink                           in_i,
  tlr_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tlr_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned N_W   = $clog2(MAX_RUN + 1);
  localparam logic [31:0] MAXS_L = 32'(GRID_CAP);
  localparam int unsigned SW = tlr_pkg::STAMP_W;
  localparam int unsigned VW = tlr_pkg::VAL_W;
  localparam int unsigned GW = tlr_pkg::NG_W;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_LOAD   = 14'b00000000000010,
    S_CHECK  = 14'b00000000000100,
    S_LOOP   = 14'b00000000001000,
    S_MUL    = 14'b00000000010000,
    S_DIVGO  = 14'b00000000100000,
    S_DIVW   = 14'b00000001000000,
    S_EMIT   = 14'b00000010000000,
    S_FIN    = 14'b00000100000000,
    S_CUTGO  = 14'b00001000000000,
    S_CUTW   = 14'b00010000000000,
    S_CUTMUL = 14'b00100000000000,
    S_WB     = 14'b01000000000000,
    S_FLAG   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [tlr_pkg::PER_W-1:0]  period_q;
  logic [tlr_pkg::MAXS_W-1:0] maxs_q;
  logic [SW-1:0]              maxdur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= tlr_pkg::RST_PERIOD;
      maxs_q   <= tlr_pkg::RST_MAXS;
      maxdur_q <= tlr_pkg::RST_MAXDUR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlr_pkg::CFG_PERIOD: period_q <= cfg_data_i[tlr_pkg::PER_W-1:0];
        tlr_pkg::CFG_MAXS:   maxs_q   <= cfg_data_i[tlr_pkg::MAXS_W-1:0];
        tlr_pkg::CFG_MAXDUR: maxdur_q <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  logic [tlr_pkg::PER_W-1:0] period;
  logic [GW-1:0]             limit;

  assign period = (period_q == '0) ? tlr_pkg::PER_W'(1) : period_q;
  assign limit  = ({19'b0, maxs_q} < MAXS_L) ? maxs_q : MAXS_L[GW-1:0];

  // Working registers of the word in progress.
  logic [tlr_pkg::CHAN_W-1:0] chan_q, chan_d;
  logic [SW-1:0]              stamp_q, stamp_d;
  logic signed [VW-1:0]       val_q, val_d;
  logic [SW-1:0]              pstamp_q, pstamp_d;
  logic signed [VW-1:0]       pval_q, pval_d;
  logic                       hp_q, hp_d;
  logic [GW-1:0]              ng_q, ng_d;
  logic [SW-1:0]              ngt_q, ngt_d;
  logic [N_W-1:0]             n_q, n_d;
  tlr_pkg::status_e           st_q, st_d;
  logic signed [VW-1:0]       v_q, v_d;
  logic signed [tlr_pkg::PROD_W-1:0] prod_q, prod_d;
  logic                       neg_q, neg_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [tlr_pkg::CHAN_W-1:0] out_chan_q, out_chan_d;
  logic [tlr_pkg::GRID_W-1:0] out_grid_q, out_grid_d;
  logic signed [VW-1:0]       out_value_q, out_value_d;
  logic                       out_last_q, out_last_d;
  tlr_pkg::status_e           out_st_q, out_st_d;

  // Channel store.
  logic                 accept, st_clear, st_rd_en, st_wr_en, rd_valid;
  logic [IDX_W-1:0]     rd_idx, wr_idx;
  tlr_pkg::chan_state_t rd_data, wr_data;

  assign accept = in_i.valid && in_i.ready;
  assign rd_idx = IDX_W'(in_i.chan);
  assign wr_idx = IDX_W'(chan_q);
  assign wr_data = '{stamp: stamp_q, value: val_q, next_grid: ng_q, next_time: ngt_q};

  tlr_chan_store #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (st_clear),
    .rd_en_i   (st_rd_en),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .rd_valid_o(rd_valid),
    .wr_en_i   (st_wr_en),
    .wr_idx_i  (wr_idx),
    .wr_data_i (wr_data)
  );

  // Shared divider.
  logic                      div_start, div_busy, div_done;
  logic [tlr_pkg::DVD_W-1:0] div_dvd, div_q;
  logic [tlr_pkg::DVS_W-1:0] div_dvs;

  tlr_div #(
    .DVD_W(tlr_pkg::DVD_W),
    .DVS_W(tlr_pkg::DVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  // Shared multiplier: interpolation product or grid index times period.
  logic signed [tlr_pkg::MUL_A_W-1:0] mul_a, off;
  logic signed [tlr_pkg::MUL_B_W-1:0] mul_b, diff;
  logic signed [tlr_pkg::PROD_W-1:0]  mul_p, prod_mag;

  assign off  = $signed({1'b0, ngt_q}) - $signed({1'b0, pstamp_q});
  assign diff = $signed({val_q[VW-1], val_q}) - $signed({pval_q[VW-1], pval_q});
  assign mul_a = (state_q == S_CUTMUL) ? $signed({20'b0, ng_q}) : off;
  assign mul_b = (state_q == S_CUTMUL) ? $signed({1'b0, period}) : diff;
  assign mul_p = mul_a * mul_b;
  assign prod_mag = prod_q[tlr_pkg::PROD_W-1] ? -prod_q : prod_q;

  // Look-ahead of the loop after the point now being emitted.
  logic [GW-1:0]  ng1;
  logic [SW-1:0]  ngt1;
  logic [N_W-1:0] n1;
  logic           more, due_now, more_after;
  logic [VW-1:0]  q16;
  logic [33:0]    cut_sum;

  assign ng1  = ng_q + GW'(1);
  assign ngt1 = ngt_q + SW'(period);
  assign n1   = n_q + N_W'(1);
  assign due_now    = ngt_q <= stamp_q;
  assign more       = (n_q < N_W'(MAX_RUN)) && (ng_q < limit) && due_now;
  assign more_after = (n1 < N_W'(MAX_RUN)) && (ng1 < limit) && (ngt1 <= stamp_q);
  assign q16        = neg_q ? -div_q[VW-1:0] : div_q[VW-1:0];
  assign cut_sum    = 34'(ng_q) + 34'(div_q[32:0]) + 34'd1;

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    chan_d = chan_q;   stamp_d = stamp_q;   val_d = val_q;
    pstamp_d = pstamp_q; pval_d = pval_q;   hp_d = hp_q;
    ng_d = ng_q;       ngt_d = ngt_q;       n_d = n_q;
    st_d = st_q;       v_d = v_q;           prod_d = prod_q;  neg_d = neg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_chan_d = out_chan_q;   out_grid_d = out_grid_q;
    out_value_d = out_value_q; out_last_d = out_last_q; out_st_d = out_st_q;
    st_clear = 1'b0; st_rd_en = 1'b0; st_wr_en = 1'b0;
    div_start = 1'b0;
    div_dvd = tlr_pkg::DVD_W'(prod_mag);
    div_dvs = stamp_q - pstamp_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.req_type) begin
            st_clear = 1'b1;
          end else if (7'(in_i.chan) < 7'(NUM_CHANNELS)) begin
            st_rd_en = 1'b1;
            chan_d   = in_i.chan;
            stamp_d  = in_i.stamp;
            val_d    = in_i.sample_value;
            state_d  = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        pstamp_d = rd_data.stamp;
        pval_d   = rd_data.value;
        ng_d     = rd_data.next_grid;
        ngt_d    = rd_data.next_time;
        hp_d     = rd_valid;
        n_d      = '0;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (stamp_q > maxdur_q) begin
          st_d    = tlr_pkg::ST_OVERRUN;
          state_d = S_FLAG;
        end else if (hp_q && (stamp_q <= pstamp_q)) begin
          st_d    = tlr_pkg::ST_NONINC;
          state_d = S_FLAG;
        end else begin
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (!more) begin
          state_d = S_FIN;
        end else if (hp_q) begin
          state_d = S_MUL;
        end else begin
          v_d     = val_q;
          state_d = S_EMIT;
        end
      end
      S_MUL: begin
        prod_d  = mul_p;
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        div_start = 1'b1;
        neg_d     = prod_q[tlr_pkg::PROD_W-1];
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          v_d     = pval_q + $signed(q16);
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_chan_d  = chan_q;
          out_grid_d  = ng_q[tlr_pkg::GRID_W-1:0];
          out_value_d = v_q;
          out_last_d  = !more_after;
          out_st_d    = tlr_pkg::ST_OK;
          if (!more_after && (ngt1 <= stamp_q)) begin
            out_st_d = (ng1 < limit) ? tlr_pkg::ST_CUT : tlr_pkg::ST_FULL;
          end
          ng_d    = ng1;
          ngt_d   = ngt1;
          n_d     = n1;
          state_d = S_LOOP;
        end
      end
      S_FIN: begin
        if (due_now && (ng_q < limit)) begin
          st_d    = tlr_pkg::ST_CUT;
          state_d = S_CUTGO;
        end else if (due_now) begin
          st_d    = tlr_pkg::ST_FULL;
          state_d = S_WB;
        end else begin
          st_d    = tlr_pkg::ST_OK;
          state_d = S_WB;
        end
      end
      S_CUTGO: begin
        div_start = 1'b1;
        div_dvd   = tlr_pkg::DVD_W'(stamp_q - ngt_q);
        div_dvs   = tlr_pkg::DVS_W'(period);
        state_d   = S_CUTW;
      end
      S_CUTW: begin
        if (div_done) begin
          ng_d    = (cut_sum > 34'(limit)) ? limit : cut_sum[GW-1:0];
          state_d = S_CUTMUL;
        end
      end
      S_CUTMUL: begin
        ngt_d   = mul_p[SW-1:0];
        state_d = S_WB;
      end
      S_WB: begin
        st_wr_en = 1'b1;
        state_d  = ((n_q == '0) && (st_q != tlr_pkg::ST_OK)) ? S_FLAG : S_IDLE;
      end
      S_FLAG: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_chan_d  = chan_q;
          out_grid_d  = ng_q[tlr_pkg::GRID_W-1:0];
          out_value_d = '0;
          out_last_d  = 1'b1;
          out_st_d    = st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;     stamp_q <= stamp_d;   val_q <= val_d;
    pstamp_q <= pstamp_d; pval_q <= pval_d;     hp_q <= hp_d;
    ng_q <= ng_d;         ngt_q <= ngt_d;       st_q <= st_d;
    v_q <= v_d;           prod_q <= prod_d;     neg_q <= neg_d;
    out_chan_q <= out_chan_d;   out_grid_q <= out_grid_d;
    out_value_q <= out_value_d; out_last_q <= out_last_d; out_st_q <= out_st_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.out_chan    = out_chan_q;
  assign out_o.grid_index  = out_grid_q;
  assign out_o.out_value   = out_value_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.status      = out_st_q;

  logic div_waiting, out_flagged;
  assign div_waiting = (state_q == S_DIVW) || (state_q == S_CUTW);
  assign out_flagged = out_valid_q && (out_st_q != tlr_pkg::ST_OK);

  `TLR_ASSERT(a_div_in_wait, !div_busy || div_waiting, "divider busy outside a wait state")
  `TLR_ASSERT(a_run_bound, n_q <= N_W'(MAX_RUN), "run counter beyond its bound")
  `TLR_ASSERT(a_flag_is_last, !out_flagged || out_last_q, "flag on a word that is not last")
  `TLR_ASSERT_NEXT(a_ready_no_div, in_i.ready && !accept, !div_busy, "divider running while idle")

endmodule

FILE: sim/timestamp_linear_resampler_tb.sv
// -----------------------------------------------------------------------------
// Timestamp linear resampler testbench
// Drives polled ADC words and start requests into the resampler and keeps an
// independent prediction of the per-channel grid state. Every result word is
// compared field by field against the oldest predicted word. Runs several
// register settings, including the extremes, with random source gaps and sink
// stalls.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamp_linear_resampler_tb;

  localparam int NCH = tlr_pkg::DEF_NUM_CHANNELS;
  localparam int RUN_LIMIT = tlr_pkg::DEF_MAX_RUN;
  localparam int unsigned CAP_LIMIT = tlr_pkg::DEF_GRID_CAP;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic                             req_type;
    logic [tlr_pkg::CHAN_W-1:0]       chan;
    logic [tlr_pkg::STAMP_W-1:0]      stamp;
    logic signed [tlr_pkg::VAL_W-1:0] sample_value;
  } poll_word_t;

  typedef struct {
    logic [tlr_pkg::CHAN_W-1:0] chan;
    logic [tlr_pkg::GRID_W-1:0] grid;
    logic [tlr_pkg::VAL_W-1:0]  value;
    logic                       last;
    logic [tlr_pkg::ST_W-1:0]   status;
  } grid_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tlr_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [tlr_pkg::CFG_W-1:0] cfg_data_i = '0;

  tlr_in_if  in_if ();
  tlr_out_if out_if ();

  timestamp_linear_resampler uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  poll_word_t pending_polls[$];
  grid_word_t grid_expected[$];
  int errors = 0;
  int polls_taken = 0;

  // Predicted register and channel state.
  logic [tlr_pkg::PER_W-1:0]   pr_period = tlr_pkg::RST_PERIOD;
  logic [tlr_pkg::MAXS_W-1:0]  pr_maxs = tlr_pkg::RST_MAXS;
  logic [tlr_pkg::STAMP_W-1:0] pr_maxdur = tlr_pkg::RST_MAXDUR;
  logic [tlr_pkg::STAMP_W-1:0] ch_stamp[NCH];
  logic [tlr_pkg::VAL_W-1:0]   ch_value[NCH];
  logic                        ch_have[NCH];
  int unsigned                 ch_grid[NCH];
  logic [tlr_pkg::STAMP_W-1:0] ch_gtime[NCH];

  // Stimulus side: the newest stamp handed to each channel.
  logic [tlr_pkg::STAMP_W-1:0] gen_last[NCH];

  function automatic void clear_channels();
    for (int c = 0; c < NCH; c++) begin
      ch_stamp[c] = '0;
      ch_value[c] = '0;
      ch_have[c] = 1'b0;
      ch_grid[c] = 0;
      ch_gtime[c] = '0;
    end
  endfunction

  function automatic void push_grid(int c, int unsigned g, logic [tlr_pkg::VAL_W-1:0] v,
                                    logic last, logic [tlr_pkg::ST_W-1:0] st);
    grid_word_t r;
    r.chan = c[tlr_pkg::CHAN_W-1:0];
    r.grid = g[tlr_pkg::GRID_W-1:0];
    r.value = v;
    r.last = last;
    r.status = st;
    grid_expected.push_back(r);
  endfunction

  function automatic void predict_grid(poll_word_t w);
    int c;
    int n;
    int unsigned period;
    int unsigned cap;
    longint off;
    longint span;
    longint diff;
    longint v;
    longint unsigned due;
    longint unsigned ng;
    logic [tlr_pkg::ST_W-1:0] st;
    c = int'(w.chan);
    n = 0;
    if (w.req_type) begin
      clear_channels();
      return;
    end
    if (w.stamp > pr_maxdur) begin
      push_grid(c, ch_grid[c], '0, 1'b1, tlr_pkg::ST_OVERRUN);
      return;
    end
    if (ch_have[c] && w.stamp <= ch_stamp[c]) begin
      push_grid(c, ch_grid[c], '0, 1'b1, tlr_pkg::ST_NONINC);
      return;
    end
    period = (pr_period == '0) ? 32'd1 : 32'(pr_period);
    cap = (32'(pr_maxs) < CAP_LIMIT) ? 32'(pr_maxs) : CAP_LIMIT;
    while (n < RUN_LIMIT && ch_grid[c] < cap && ch_gtime[c] <= w.stamp) begin
      v = w.sample_value;
      if (ch_have[c]) begin
        off = longint'(ch_gtime[c]) - longint'(ch_stamp[c]);
        span = longint'(w.stamp) - longint'(ch_stamp[c]);
        diff = longint'(w.sample_value) - longint'($signed(ch_value[c]));
        v = longint'($signed(ch_value[c])) + (off * diff) / span;
      end
      push_grid(c, ch_grid[c], v[tlr_pkg::VAL_W-1:0], 1'b0, tlr_pkg::ST_OK);
      n++;
      ch_grid[c] += 1;
      ch_gtime[c] += period;
    end
    st = tlr_pkg::ST_OK;
    if (ch_gtime[c] <= w.stamp && ch_grid[c] < cap) begin
      // Run cut: jump past the stamp, never beyond the capacity.
      due = longint'(w.stamp - ch_gtime[c]) / period + 1;
      ng = ch_grid[c] + due;
      if (ng > cap) ng = cap;
      ch_grid[c] = 32'(ng);
      ch_gtime[c] = 32'(ng * period);
      st = tlr_pkg::ST_CUT;
    end else if (ch_gtime[c] <= w.stamp) begin
      st = tlr_pkg::ST_FULL;
    end
    ch_stamp[c] = w.stamp;
    ch_value[c] = w.sample_value;
    ch_have[c] = 1'b1;
    if (n == 0) begin
      if (st != tlr_pkg::ST_OK) push_grid(c, ch_grid[c], '0, 1'b1, st);
    end else begin
      grid_expected[$].last = 1'b1;
      grid_expected[$].status = st;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Source side: bursts of words with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    poll_word_t w;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.req_type <= 1'b0;
      in_if.chan <= '0;
      in_if.stamp <= '0;
      in_if.sample_value <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_if.valid && !in_if.ready) begin
      // Word still on offer.
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_if.valid <= 1'b0;
    end else if (pending_polls.size() > 0) begin
      w = pending_polls.pop_front();
      in_if.valid <= 1'b1;
      in_if.req_type <= w.req_type;
      in_if.chan <= w.chan;
      in_if.stamp <= w.stamp;
      in_if.sample_value <= w.sample_value;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 16);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Sink side: random stalls in alternating stretches, plus one long hold-off
  // that lets the block back up into its input.
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic [8:0] sink_cycle = '0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      sink_cycle <= '0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && polls_taken >= 40) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_if.ready <= 1'b0;
    end else begin
      sink_cycle <= sink_cycle + 1;
      out_if.ready <= sink_cycle[8] ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Prediction, checking and the idle watchdog.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    poll_word_t w;
    grid_word_t e;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        w.req_type = in_if.req_type;
        w.chan = in_if.chan;
        w.stamp = in_if.stamp;
        w.sample_value = in_if.sample_value;
        predict_grid(w);
        polls_taken <= polls_taken + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (grid_expected.size() == 0) begin
          report_mismatch("unexpected word", out_if.grid_index, 0);
        end else begin
          e = grid_expected.pop_front();
          if (out_if.out_chan !== e.chan) report_mismatch("out_chan", out_if.out_chan, e.chan);
          if (out_if.grid_index !== e.grid)
            report_mismatch("grid_index", out_if.grid_index, e.grid);
          if (out_if.out_value !== e.value)
            report_mismatch("out_value", out_if.out_value, e.value);
          if (out_if.last_of_run !== e.last)
            report_mismatch("last_of_run", out_if.last_of_run, e.last);
          if (out_if.status !== e.status) report_mismatch("status", out_if.status, e.status);
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_poll(logic rt, int c, logic [tlr_pkg::STAMP_W-1:0] s,
                          logic [tlr_pkg::VAL_W-1:0] v);
    poll_word_t w;
    w.req_type = rt;
    w.chan = c[tlr_pkg::CHAN_W-1:0];
    w.stamp = s;
    w.sample_value = v;
    pending_polls.push_back(w);
    if (rt) begin
      for (int i = 0; i < NCH; i++) gen_last[i] = '0;
    end else if (s > gen_last[c]) begin
      gen_last[c] = s;
    end
  endtask

  task automatic write_reg(tlr_pkg::cfg_idx_e idx, logic [tlr_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // The block takes the new value from the next edge on.
    case (idx)
      tlr_pkg::CFG_PERIOD: pr_period = data[tlr_pkg::PER_W-1:0];
      tlr_pkg::CFG_MAXS:   pr_maxs = data[tlr_pkg::MAXS_W-1:0];
      default:             pr_maxdur = data;
    endcase
  endtask

  task automatic configure(logic [tlr_pkg::PER_W-1:0] per, logic [tlr_pkg::MAXS_W-1:0] maxs,
                           logic [tlr_pkg::STAMP_W-1:0] maxdur);
    write_reg(tlr_pkg::CFG_PERIOD, 32'(per));
    write_reg(tlr_pkg::CFG_MAXS, 32'(maxs));
    write_reg(tlr_pkg::CFG_MAXDUR, maxdur);
  endtask

  // Waits until every word is taken and every predicted word has come, then
  // lets a word that gives no result finish its work in the block.
  task automatic drain();
    while (pending_polls.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (in_if.valid || grid_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly increasing per-channel stamps with random codes; the rest are
  // start requests, repeated or slightly older stamps and raw noise.
  task automatic add_random(int count);
    int r;
    int c;
    int unsigned step;
    logic [tlr_pkg::STAMP_W-1:0] s;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      c = $urandom_range(0, NCH - 1);
      step = (pr_period == 0) ? 4 : 3 * pr_period + 1;
      if (r < 4) begin
        add_poll(1'b1, $urandom_range(0, NCH - 1), $urandom, tlr_pkg::VAL_W'($urandom));
      end else if (r < 10) begin
        add_poll(1'b0, c, $urandom, tlr_pkg::VAL_W'($urandom));
      end else if (r < 16) begin
        s = gen_last[c] - $urandom_range(0, 2);
        add_poll(1'b0, c, s, tlr_pkg::VAL_W'($urandom));
      end else begin
        s = gen_last[c] + $urandom_range(1, step);
        if (s < gen_last[c]) s = 32'hFFFF_FFFF;
        add_poll(1'b0, c, s, tlr_pkg::VAL_W'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NCH; i++) gen_last[i] = '0;
    clear_channels();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fine grid: first values, interpolation over full scale, a long run cut.
    configure(16'd100, 13'd4096, 32'hFFFF_FFFF);
    add_poll(1'b0, 0, 32'd0, 16'sh7FFF);
    add_poll(1'b0, 0, 32'd250, 16'sh8000);
    add_poll(1'b0, 0, 32'd250, 16'sd1);
    add_poll(1'b0, 0, 32'd100000, 16'sh7FFF);
    add_poll(1'b0, 15, 32'd50, 16'sd5);
    add_poll(1'b0, 15, 32'd60, -16'sd7);
    add_poll(1'b0, 15, 32'd460, 16'sh8000);
    add_poll(1'b0, 3, 32'hFFFF_FFFF, 16'shFFFF);
    add_poll(1'b1, 15, 32'hFFFF_FFFF, 16'shFFFF);
    add_poll(1'b0, 7, 32'd0, -16'sd100);
    add_poll(1'b0, 7, 32'd1000, 16'sd100);
    add_random(60);
    drain();

    // Tiny capacity and duration: overruns and a full channel.
    configure(16'd1, 13'd8, 32'd5000);
    add_poll(1'b1, 0, '0, '0);
    add_poll(1'b0, 2, 32'd6000, 16'sd3);
    add_poll(1'b0, 2, 32'd5000, 16'sd3);
    add_poll(1'b0, 2, 32'd5001, 16'sd3);
    add_poll(1'b0, 2, 32'd4000, 16'sd3);
    add_random(40);
    drain();

    // All registers at zero: period acts as one, nothing fits.
    configure(16'd0, 13'd0, 32'd0);
    add_poll(1'b1, 0, '0, '0);
    add_poll(1'b0, 4, 32'd0, 16'sd9);
    add_poll(1'b0, 4, 32'd1, 16'sd9);
    add_random(20);
    drain();

    // Widest grid and a capacity above the maximum.
    configure(16'hFFFF, 13'h1FFF, 32'hFFFF_FFFF);
    add_poll(1'b1, 0, '0, '0);
    add_poll(1'b0, 9, 32'hFFFF_FFFF, 16'sh7FFF);
    add_random(50);
    drain();

    configure(16'd37, 13'd4096, 32'h0FFF_FFFF);
    add_poll(1'b1, 0, '0, '0);
    add_random(50);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: timestamp_linear_resampler.f
+incdir+hw/rtl
hw/rtl/tlr_pkg.sv
hw/rtl/tlr_if.sv
hw/rtl/tlr_div.sv
hw/rtl/tlr_chan_store.sv
hw/rtl/timestamp_linear_resampler.sv
sim/timestamp_linear_resampler_tb.sv
